// ----- hdl/mmgn_pkg.sv -----
package mmgn_pkg;

    localparam int DEF_MAP_ROWS    = 64;
    localparam int DEF_MAP_COLS    = 64;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int POS_W      = 6;
    localparam int SAMPLE_W   = 16;
    localparam int LIMIT_W    = 11;
    localparam int CELL_IDX_W = 22;
    localparam int FRAC_W     = 16;
    localparam int LEVEL_W    = FRAC_W + 1;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    localparam logic [LEVEL_W-1:0] ONE_Q16 = LEVEL_W'(1) << FRAC_W;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

endpackage

// ----- hdl/mmgn_ram.sv -----
module mmgn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                                        aclk,
    input  logic                                        en,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                            wdata,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/mmgn_div.sv -----
module mmgn_div import mmgn_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [SAMPLE_BITS+FRAC_W-1:0]   numer,
    input  logic [SAMPLE_BITS-1:0]          denom,
    output logic                            done,
    output logic [LEVEL_W-1:0]              quot
);

    localparam int SB    = SAMPLE_BITS;
    localparam int NUM_W = SB + FRAC_W;
    localparam int CNT_W = $clog2(LEVEL_W + 1);

    logic [SB-1:0]      rem_reg,  rem_next;
    logic [LEVEL_W-1:0] low_reg,  low_next;
    logic [LEVEL_W-1:0] quot_reg, quot_next;
    logic [SB-1:0]      den_reg,  den_next;
    logic [CNT_W-1:0]   cnt_reg,  cnt_next;
    logic               done_reg, done_next;

    logic [SB:0] trial;
    logic [SB:0] diff;
    logic        fits;

    assign trial = {rem_reg, low_reg[LEVEL_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = {1'b0, numer[NUM_W-1:LEVEL_W]};
            low_next = numer[LEVEL_W-1:0];
            den_next = denom;
            cnt_next = CNT_W'(LEVEL_W);
        end else if (cnt_reg != '0) begin
            rem_next  = fits ? diff[SB-1:0] : trial[SB-1:0];
            low_next  = {low_reg[LEVEL_W-2:0], 1'b0};
            quot_next = {quot_reg[LEVEL_W-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- hdl/min_max_grid_normalizer.sv -----
// Loads: one transaction accepted per cycle while no read is in progress.
// Reads: the cell is fetched, then, when a span exists, the bit-serial divider runs
// (17 quotient steps); flat, clamped or off-grid reads skip the division.
// Input blocks until a read's result registers.
// aresetn (synchronous) sets the extremes to their empty values and drops m_tvalid;
// grid contents are undefined until written.
module min_max_grid_normalizer import mmgn_pkg::*; #(
    parameter int MAP_ROWS    = DEF_MAP_ROWS,
    parameter int MAP_COLS    = DEF_MAP_COLS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // row, col, sample, first
    input  logic                  s_tuser,   // func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // level
    output logic                  m_tuser    // flat
);

    localparam int CELLS  = MAP_ROWS * MAP_COLS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SB     = SAMPLE_BITS;
    localparam int NUM_W  = SB + FRAC_W;

    localparam logic signed [SB-1:0] LOW_INIT  = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] HIGH_INIT = {1'b1, {(SB-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    col;
    logic [SAMPLE_W-1:0] sample_in;
    logic                first;
    logic                func;
    logic signed [SB-1:0] value;

    assign row       = s_tdata[5:0];
    assign col       = s_tdata[11:6];
    assign sample_in = s_tdata[27:12];
    assign first     = s_tdata[28];
    assign func      = s_tuser;

    generate
        if (SB <= SAMPLE_W) begin : g_narrow
            assign value = signed'(sample_in[SB-1:0]);
        end else begin : g_wide
            assign value = signed'({{(SB-SAMPLE_W){1'b0}}, sample_in});
        end
    endgenerate

    logic                  on_grid;
    logic [CELL_IDX_W-1:0] cell_full;
    logic                  s_acc;
    logic                  load_acc;
    logic                  read_acc;

    assign on_grid   = (LIMIT_W'(row) < LIMIT_W'(MAP_ROWS)) &&
                       (LIMIT_W'(col) < LIMIT_W'(MAP_COLS));
    assign cell_full = CELL_IDX_W'(row) * CELL_IDX_W'(MAP_COLS) + CELL_IDX_W'(col);
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign load_acc  = s_acc && on_grid && (func == FUNC_LOAD);
    assign read_acc  = s_acc && (func == FUNC_READ);

    logic [SB-1:0] rd_data;

    mmgn_ram #(
        .WIDTH (SB),
        .DEPTH (CELLS)
    ) u_ram (
        .aclk  (aclk),
        .en    (s_acc && on_grid),
        .we    (func == FUNC_LOAD),
        .addr  (cell_full[ADDR_W-1:0]),
        .wdata (value),
        .rdata (rd_data)
    );

    logic signed [SB-1:0] lo_reg, lo_next;
    logic signed [SB-1:0] hi_reg, hi_next;

    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (load_acc) begin
            if (first) begin
                lo_next = value;
                hi_next = value;
            end else begin
                if (value < lo_reg) begin
                    lo_next = value;
                end
                if (value > hi_reg) begin
                    hi_next = value;
                end
            end
        end
    end

    logic signed [SB-1:0] s_word;
    logic [SB:0]          span_full;
    logic [SB:0]          off_full;
    logic [SB-1:0]        span;
    logic [NUM_W-1:0]     numer;
    logic                 no_span;

    assign s_word    = signed'(rd_data);
    assign span_full = {hi_reg[SB-1], hi_reg} - {lo_reg[SB-1], lo_reg};
    assign off_full  = {s_word[SB-1], s_word} - {lo_reg[SB-1], lo_reg};
    assign span      = span_full[SB-1:0];
    assign numer     = {off_full[SB-1:0], {FRAC_W{1'b0}}} + NUM_W'(span >> 1);
    assign no_span   = (hi_reg <= lo_reg);

    logic               div_start;
    logic               div_done;
    logic [LEVEL_W-1:0] div_quot;

    mmgn_div #(
        .SAMPLE_BITS (SB)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (numer),
        .denom   (span),
        .done    (div_done),
        .quot    (div_quot)
    );

    logic               on_grid_reg,   on_grid_next;
    logic [LEVEL_W-1:0] res_level_reg, res_level_next;
    logic               res_flat_reg,  res_flat_next;
    logic               m_tvalid_reg,  m_tvalid_next;
    logic [LEVEL_W-1:0] m_level_reg,   m_level_next;
    logic               m_flat_reg,    m_flat_next;

    always_comb begin
        state_next     = state_reg;
        on_grid_next   = on_grid_reg;
        res_level_next = res_level_reg;
        res_flat_next  = res_flat_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_level_next   = m_level_reg;
        m_flat_next    = m_flat_reg;
        div_start      = 1'b0;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (read_acc) begin
                    on_grid_next = on_grid;
                    state_next   = ST_FETCH;
                end
            end
            ST_FETCH: begin
                res_level_next = '0;
                res_flat_next  = 1'b0;
                state_next     = ST_EMIT;
                if (!on_grid_reg) begin
                    res_flat_next = 1'b0;
                end else if (no_span) begin
                    res_flat_next = 1'b1;
                end else if (s_word <= lo_reg) begin
                    res_level_next = '0;
                end else if (s_word >= hi_reg) begin
                    res_level_next = ONE_Q16;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    res_level_next = (div_quot > ONE_Q16) ? ONE_Q16 : div_quot;
                    res_flat_next  = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_level_next  = res_level_reg;
                    m_flat_next   = res_flat_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            lo_reg       <= LOW_INIT;
            hi_reg       <= HIGH_INIT;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
        end
    end

    always_ff @(posedge aclk) begin
        on_grid_reg   <= on_grid_next;
        res_level_reg <= res_level_next;
        res_flat_reg  <= res_flat_next;
        m_level_reg   <= m_level_next;
        m_flat_reg    <= m_flat_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W-LEVEL_W){1'b0}}, m_level_reg};
    assign m_tuser  = m_flat_reg;

endmodule

// ----- hdl/mmgn_checker.sv -----
module mmgn_checker import mmgn_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_flat_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[LEVEL_W-1:0] == '0)
        else $error("flat result with non-zero level");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[LEVEL_W-1:0] <= ONE_Q16
                  && m_tdata[OUT_DATA_W-1:LEVEL_W] == '0)
        else $error("level out of range");

    a_read_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == FUNC_READ |=> !s_tready)
        else $error("transaction accepted while a read is in progress");

endmodule

bind min_max_grid_normalizer mmgn_checker u_mmgn_checker (.*);

// ----- sim/min_max_grid_normalizer_tb.sv -----
`timescale 1ns / 1ps

module min_max_grid_normalizer_tb;
    import mmgn_pkg::*;

    typedef struct packed {
        logic                       func;
        logic [POS_W-1:0]           row;
        logic [POS_W-1:0]           col;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       first;
    } height_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               flat;
    } level_due_t;

    localparam int CELLS = DEF_MAP_ROWS * DEF_MAP_COLS;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;    // row, col, sample, first
    logic                  s_tuser = 1'b0;  // func
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // level
    logic                  m_tuser;         // flat

    height_item_t pending_items[$];
    level_due_t   expected_levels[$];
    height_item_t on_bus;
    int           send_idle_pct = 21;
    int           recv_stall_pct = 62;
    int           bad_count = 0;

    // predictor state
    logic signed [SAMPLE_W-1:0] height_grid[CELLS];
    logic signed [SAMPLE_W-1:0] lowest_height;
    logic signed [SAMPLE_W-1:0] highest_height;

    // generation-side bookkeeping of written cells
    bit written_map[CELLS];
    int written_cells[$];
    int band_lo = 0;
    int band_w = 65535;

    min_max_grid_normalizer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    task automatic advance_grid(input height_item_t it);
        int         cell_idx;
        longint     s;
        longint     lo;
        longint     hi;
        longint     span;
        longint     q;
        level_due_t due;
        cell_idx = int'({it.row, it.col});
        if (it.func == FUNC_LOAD) begin
            height_grid[cell_idx] = it.sample;
            if (it.first) begin
                lowest_height = it.sample;
                highest_height = it.sample;
            end else begin
                if (it.sample < lowest_height) lowest_height = it.sample;
                if (it.sample > highest_height) highest_height = it.sample;
            end
        end else begin
            s = longint'(height_grid[cell_idx]);
            lo = longint'(lowest_height);
            hi = longint'(highest_height);
            due.flat = 1'b0;
            if (hi <= lo) begin
                due.level = '0;
                due.flat = 1'b1;
            end else if (s <= lo) begin
                due.level = '0;
            end else if (s >= hi) begin
                due.level = ONE_Q16;
            end else begin
                span = hi - lo;
                q = ((s - lo) * 65536 + span / 2) / span;
                if (q > 65536) q = 65536;
                due.level = LEVEL_W'(q);
            end
            expected_levels.push_back(due);
        end
    endtask

    task automatic log_fault(input string what);
        bad_count++;
        if (bad_count <= 10) $display("%0t: %s", $time, what);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            lowest_height = 16'sh7fff;
            highest_height = 16'sh8000;
        end else begin
            if (s_tvalid && s_tready) advance_grid(on_bus);
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {3'b000, on_bus.first, on_bus.sample, on_bus.col, on_bus.row};
                    s_tuser <= on_bus.func;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin : monitor
        level_due_t due;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_levels.size() == 0) begin
                    log_fault($sformatf("unexpected result level=%0d flat=%0b",
                                        m_tdata[LEVEL_W-1:0], m_tuser));
                end else begin
                    due = expected_levels.pop_front();
                    if (m_tdata[LEVEL_W-1:0] !== due.level || m_tuser !== due.flat)
                        log_fault($sformatf("level exp %0d got %0d, flat exp %0b got %0b",
                                            due.level, m_tdata[LEVEL_W-1:0],
                                            due.flat, m_tuser));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic add_item(input logic func, input int row, input int col,
                            input int sample, input logic first);
        height_item_t it;
        int           cell_idx;
        it.func = func;
        it.row = POS_W'(row);
        it.col = POS_W'(col);
        it.sample = SAMPLE_W'(sample);
        it.first = first;
        cell_idx = int'({it.row, it.col});
        if (func == FUNC_LOAD && !written_map[cell_idx]) begin
            written_map[cell_idx] = 1'b1;
            written_cells.push_back(cell_idx);
        end
        pending_items.push_back(it);
    endtask

    task automatic add_random(input int count);
        int cell_idx;
        int sample;
        for (int n = 0; n < count; n++) begin
            if (written_cells.size() == 0 || $urandom_range(99) < 50) begin
                if ($urandom_range(3) == 0 && written_cells.size() > 0)
                    cell_idx = written_cells[$urandom_range(written_cells.size() - 1)];
                else
                    cell_idx = $urandom_range(CELLS - 1);
                if ($urandom_range(19) == 0) begin
                    // restart the extremes with a fresh band
                    case ($urandom_range(3))
                        0: band_w = 0;
                        1: band_w = 3;
                        2: band_w = 255;
                        default: band_w = 65535;
                    endcase
                    band_lo = $urandom_range(65535);
                    add_item(FUNC_LOAD, cell_idx >> POS_W, cell_idx % DEF_MAP_COLS,
                             band_lo, 1'b1);
                end else begin
                    if ($urandom_range(3) == 0)
                        sample = $urandom_range(65535);
                    else
                        sample = band_lo + $urandom_range(band_w);
                    add_item(FUNC_LOAD, cell_idx >> POS_W, cell_idx % DEF_MAP_COLS,
                             sample, 1'($urandom_range(1)));
                end
            end else begin
                cell_idx = written_cells[$urandom_range(written_cells.size() - 1)];
                add_item(FUNC_READ, cell_idx >> POS_W, cell_idx % DEF_MAP_COLS,
                         $urandom_range(65535), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // single sample and equal samples: no span
        add_item(FUNC_LOAD, 0, 0, -32768, 1'b1);
        add_item(FUNC_READ, 0, 0, 0, 1'b0);
        add_item(FUNC_LOAD, 63, 63, -32768, 1'b0);
        add_item(FUNC_READ, 63, 63, 0, 1'b0);
        // full-scale span
        add_item(FUNC_LOAD, 0, 63, 32767, 1'b0);
        add_item(FUNC_READ, 0, 0, 0, 1'b0);
        add_item(FUNC_READ, 0, 63, 0, 1'b0);
        add_item(FUNC_LOAD, 63, 0, 0, 1'b0);
        add_item(FUNC_READ, 63, 0, 0, 1'b0);
        add_item(FUNC_LOAD, 21, 42, -1, 1'b0);
        add_item(FUNC_READ, 21, 42, -1, 1'b1);
        add_item(FUNC_LOAD, 42, 21, 1, 1'b0);
        add_item(FUNC_READ, 42, 21, 32767, 1'b1);
        // restart, then stale cells outside the new range
        add_item(FUNC_LOAD, 1, 1, 100, 1'b1);
        add_item(FUNC_READ, 1, 1, 0, 1'b0);
        add_item(FUNC_LOAD, 1, 2, 200, 1'b0);
        add_item(FUNC_READ, 0, 0, 0, 1'b0);
        add_item(FUNC_READ, 0, 63, 0, 1'b0);
        add_item(FUNC_READ, 1, 1, 0, 1'b0);
        add_item(FUNC_LOAD, 1, 3, 150, 1'b0);
        add_item(FUNC_READ, 1, 3, 0, 1'b0);
        add_item(FUNC_LOAD, 1, 4, 101, 1'b0);
        add_item(FUNC_READ, 1, 4, 0, 1'b0);
        add_item(FUNC_READ, 1, 2, 0, 1'b0);

        add_random(360);
        while (pending_items.size() != 0) @(posedge aclk);
        send_idle_pct = 62;
        recv_stall_pct = 21;
        add_random(360);
        while (pending_items.size() != 0) @(posedge aclk);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        add_random(360);

        while (pending_items.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_levels.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (expected_levels.size() != 0) log_fault("results still outstanding");
        if (bad_count == 0) begin
            $display("PASS min_max_grid_normalizer");
        end else begin
            $display("FAIL min_max_grid_normalizer");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL min_max_grid_normalizer");
        $finish;
    end

endmodule
